// ===== rtl/core/qte_pkg.sv =====
package qte_pkg;

    localparam int DEF_CORDIC_STAGES  = 16;
    localparam int DEF_QUAT_FRAC_BITS = 14;

    localparam int QUAT_W    = 16;
    localparam int PROD_W    = 32;
    localparam int WIDE_W    = 64;
    localparam int S30_W     = 30;
    localparam int SQ_W      = 60;
    localparam int RAD_W     = 61;
    localparam int ROOT_W    = 31;
    localparam int ISQ_STEPS = 31;
    localparam int CV_W      = 34;
    localparam int ACC_W     = 32;
    localparam int ANG_W     = 16;
    localparam int ANG_FRAC  = 16;
    localparam int ANGX_W    = 14;
    localparam int ANGYZ_W   = 15;
    localparam int ANGX_LIM  = 5760;
    localparam int ANGYZ_LIM = 11520;

    localparam int NORM_STEPS       = 13;
    localparam int NORM_RIGHT_STEPS = 7;
    // right steps shift when mx >= 2^lim, left steps when mx < 2^lim
    localparam int NORM_SH  [NORM_STEPS] = '{32, 16, 8, 4, 2, 1, 1, 16, 8, 4, 2, 1, 1};
    localparam int NORM_LIM [NORM_STEPS] = '{62, 46, 38, 34, 32, 31, 30, 13, 21, 25, 27, 28, 29};

    localparam int ATAN_TAB_LEN = 24;
    localparam logic signed [ACC_W-1:0] ATAN_TAB [ATAN_TAB_LEN] = '{
        32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
        32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
        32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
        32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
        32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
        32'sd229,       32'sd115,       32'sd57,       32'sd29
    };

    typedef struct packed {
        logic                     clamp;
        logic                     sneg;
        logic [S30_W-1:0]         s30;
        logic signed [WIDE_W-1:0] ny;
        logic signed [WIDE_W-1:0] dy;
        logic signed [WIDE_W-1:0] nz;
        logic signed [WIDE_W-1:0] dz;
    } t_side;

    typedef struct packed {
        logic clamp;
        logic sneg;
    } t_xflag;

    typedef struct packed {
        logic [WIDE_W-1:0] an;
        logic [WIDE_W-1:0] ad;
        logic [WIDE_W-1:0] mx;
        logic              nneg;
        logic              dneg;
        logic              zero;
        t_xflag            flag;
    } t_norm;

    typedef struct packed {
        logic signed [CV_W-1:0]  x;
        logic signed [CV_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
        t_xflag                  flag;
    } t_cord;

endpackage

// ===== rtl/core/qte_front.sv =====
module qte_front
    import qte_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = DEF_QUAT_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [QUAT_W-1:0] i_qx,
    input  logic signed [QUAT_W-1:0] i_qy,
    input  logic signed [QUAT_W-1:0] i_qz,
    input  logic signed [QUAT_W-1:0] i_qw,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [RAD_W-1:0]         o_rad,
    output t_side                    o_side
);

    localparam int F2  = 2 * QUAT_FRAC_BITS;
    localparam int SHR = (F2 >= S30_W) ? F2 - S30_W : 0;
    localparam int SHL = (F2 >= S30_W) ? 0 : S30_W - F2;
    localparam logic [WIDE_W-1:0] ONE = WIDE_W'(1) << F2;
    localparam int STG = 5;

    logic [STG-1:0] r_v;
    logic [STG-1:0] adv;

    logic signed [PROD_W-1:0] r_wx, r_yz, r_wy, r_zx, r_xx, r_yy, r_wz, r_xy, r_zz;
    logic signed [WIDE_W-1:0] r_s, r_ny, r_dy, r_nz, r_dz;
    t_side                    r_side2, r_side3;
    logic [SQ_W-1:0]          r_sq;
    logic [RAD_W-1:0]         r_rad;
    t_side                    r_side4;

    logic [WIDE_W-1:0] smag;
    logic [WIDE_W-1:0] sshift;

    always_comb begin
        adv[STG-1] = !r_v[STG-1] || i_ready;
        for (int k = STG - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < STG; k++) begin
                if (adv[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    assign smag   = r_s[WIDE_W-1] ? WIDE_W'(-r_s) : WIDE_W'(r_s);
    assign sshift = (F2 >= S30_W) ? (smag >> SHR) : (smag << SHL);

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_wx <= i_qw * i_qx;
            r_yz <= i_qy * i_qz;
            r_wy <= i_qw * i_qy;
            r_zx <= i_qz * i_qx;
            r_xx <= i_qx * i_qx;
            r_yy <= i_qy * i_qy;
            r_wz <= i_qw * i_qz;
            r_xy <= i_qx * i_qy;
            r_zz <= i_qz * i_qz;
        end
        if (adv[1]) begin
            r_s  <= (WIDE_W'(r_wx) - WIDE_W'(r_yz)) <<< 1;
            r_ny <= (WIDE_W'(r_wy) + WIDE_W'(r_zx)) <<< 1;
            r_nz <= (WIDE_W'(r_wz) + WIDE_W'(r_xy)) <<< 1;
            r_dy <= $signed(ONE) - ((WIDE_W'(r_xx) + WIDE_W'(r_yy)) <<< 1);
            r_dz <= $signed(ONE) - ((WIDE_W'(r_zz) + WIDE_W'(r_xx)) <<< 1);
        end
        if (adv[2]) begin
            r_side2.clamp <= smag >= ONE;
            r_side2.sneg  <= r_s[WIDE_W-1];
            r_side2.s30   <= sshift[S30_W-1:0];
            r_side2.ny    <= r_ny;
            r_side2.dy    <= r_dy;
            r_side2.nz    <= r_nz;
            r_side2.dz    <= r_dz;
        end
        if (adv[3]) begin
            r_sq    <= r_side2.s30 * r_side2.s30;
            r_side3 <= r_side2;
        end
        if (adv[4]) begin
            r_rad   <= (RAD_W'(1) << SQ_W) - RAD_W'(r_sq);
            r_side4 <= r_side3;
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[STG-1];
    assign o_rad   = r_rad;
    assign o_side  = r_side4;

endmodule

// ===== rtl/core/qte_isqrt.sv =====
module qte_isqrt
    import qte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [RAD_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic [ISQ_STEPS-1:0] r_v;
    logic [ISQ_STEPS-1:0] adv;
    logic [RAD_W-1:0]     r_rem  [ISQ_STEPS];
    logic [RAD_W-1:0]     r_res  [ISQ_STEPS];
    t_side                r_side [ISQ_STEPS];

    always_comb begin
        adv[ISQ_STEPS-1] = !r_v[ISQ_STEPS-1] || i_ready;
        for (int k = ISQ_STEPS - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < ISQ_STEPS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ISQ_STEPS - 1 - k));
        logic [RAD_W-1:0] rem_in, res_in, trial;
        t_side            side_in;
        if (k == 0) begin : g_first
            assign rem_in  = i_rad;
            assign res_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign res_in  = r_res[k-1];
            assign side_in = r_side[k-1];
        end
        assign trial = res_in + BIT;
        always_ff @(posedge i_clk) begin
            if (adv[k]) begin
                r_side[k] <= side_in;
                if (rem_in >= trial) begin
                    r_rem[k] <= rem_in - trial;
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_rem[k] <= rem_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[ISQ_STEPS-1];
    assign o_root  = r_res[ISQ_STEPS-1][ROOT_W-1:0];
    assign o_side  = r_side[ISQ_STEPS-1];

endmodule

// ===== rtl/core/qte_atan2.sv =====
module qte_atan2
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [WIDE_W-1:0] i_num,
    input  logic signed [WIDE_W-1:0] i_den,
    input  t_xflag                   i_flag,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [ANG_W-1:0]  o_angle,
    output t_xflag                   o_flag
);

    localparam int CRD0 = NORM_STEPS + 1;
    localparam int STG  = CRD0 + CORDIC_STAGES + 2;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (ANG_FRAC - 1);

    logic [STG-1:0] r_v;
    logic [STG-1:0] adv;

    t_norm                  r_nrm [NORM_STEPS+1];
    t_cord                  r_crd [CORDIC_STAGES+1];
    logic signed [ANG_W-1:0] r_angle;
    t_xflag                 r_flag;

    logic [WIDE_W-1:0]       an0, ad0;
    logic signed [CV_W-1:0]  px, py;
    logic signed [ACC_W-1:0] rnd;

    always_comb begin
        adv[STG-1] = !r_v[STG-1] || i_ready;
        for (int k = STG - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < STG; k++) begin
                if (adv[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    assign an0 = i_num[WIDE_W-1] ? WIDE_W'(-i_num) : WIDE_W'(i_num);
    assign ad0 = i_den[WIDE_W-1] ? WIDE_W'(-i_den) : WIDE_W'(i_den);

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_nrm[0].an   <= an0;
            r_nrm[0].ad   <= ad0;
            r_nrm[0].mx   <= (an0 > ad0) ? an0 : ad0;
            r_nrm[0].nneg <= i_num[WIDE_W-1];
            r_nrm[0].dneg <= i_den[WIDE_W-1];
            r_nrm[0].zero <= (an0 == '0) && (ad0 == '0);
            r_nrm[0].flag <= i_flag;
        end
    end

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam logic [WIDE_W-1:0] LIM = WIDE_W'(1) << NORM_LIM[j];
        logic do_shift;
        assign do_shift = (j < NORM_RIGHT_STEPS) ? (r_nrm[j].mx >= LIM) : (r_nrm[j].mx < LIM);
        always_ff @(posedge i_clk) begin
            if (adv[j+1]) begin
                r_nrm[j+1] <= r_nrm[j];
                if (do_shift) begin
                    if (j < NORM_RIGHT_STEPS) begin
                        r_nrm[j+1].an <= r_nrm[j].an >> NORM_SH[j];
                        r_nrm[j+1].ad <= r_nrm[j].ad >> NORM_SH[j];
                        r_nrm[j+1].mx <= r_nrm[j].mx >> NORM_SH[j];
                    end else begin
                        r_nrm[j+1].an <= r_nrm[j].an << NORM_SH[j];
                        r_nrm[j+1].ad <= r_nrm[j].ad << NORM_SH[j];
                        r_nrm[j+1].mx <= r_nrm[j].mx << NORM_SH[j];
                    end
                end
            end
        end
    end

    assign py = r_nrm[NORM_STEPS].nneg ? -$signed(CV_W'(r_nrm[NORM_STEPS].an[S30_W:0]))
                                       :  $signed(CV_W'(r_nrm[NORM_STEPS].an[S30_W:0]));
    assign px = r_nrm[NORM_STEPS].dneg ? -$signed(CV_W'(r_nrm[NORM_STEPS].ad[S30_W:0]))
                                       :  $signed(CV_W'(r_nrm[NORM_STEPS].ad[S30_W:0]));

    always_ff @(posedge i_clk) begin
        if (adv[CRD0]) begin
            r_crd[0].zero <= r_nrm[NORM_STEPS].zero;
            r_crd[0].flag <= r_nrm[NORM_STEPS].flag;
            if (px < 0 && py >= 0) begin
                r_crd[0].x   <= py;
                r_crd[0].y   <= -px;
                r_crd[0].acc <= ATAN_TAB[0] <<< 1;
            end else if (px < 0) begin
                r_crd[0].x   <= -py;
                r_crd[0].y   <= px;
                r_crd[0].acc <= -(ATAN_TAB[0] <<< 1);
            end else begin
                r_crd[0].x   <= px;
                r_crd[0].y   <= py;
                r_crd[0].acc <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        logic signed [CV_W-1:0] xs, ys;
        assign xs = r_crd[i].x >>> i;
        assign ys = r_crd[i].y >>> i;
        always_ff @(posedge i_clk) begin
            if (adv[CRD0+1+i]) begin
                r_crd[i+1].zero <= r_crd[i].zero;
                r_crd[i+1].flag <= r_crd[i].flag;
                if (r_crd[i].y >= 0) begin
                    r_crd[i+1].x   <= r_crd[i].x + ys;
                    r_crd[i+1].y   <= r_crd[i].y - xs;
                    r_crd[i+1].acc <= r_crd[i].acc + ATAN_TAB[i];
                end else begin
                    r_crd[i+1].x   <= r_crd[i].x - ys;
                    r_crd[i+1].y   <= r_crd[i].y + xs;
                    r_crd[i+1].acc <= r_crd[i].acc - ATAN_TAB[i];
                end
            end
        end
    end

    assign rnd = (r_crd[CORDIC_STAGES].acc + HALF) >>> ANG_FRAC;

    always_ff @(posedge i_clk) begin
        if (adv[STG-1]) begin
            r_angle <= r_crd[CORDIC_STAGES].zero ? '0 : rnd[ANG_W-1:0];
            r_flag  <= r_crd[CORDIC_STAGES].flag;
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[STG-1];
    assign o_angle = r_angle;
    assign o_flag  = r_flag;

endmodule

// ===== rtl/core/quaternion_to_euler_angles.sv =====
// Quaternion to Euler angles. Each input word carries x, y, z, w in signed
// fixed point with QUAT_FRAC_BITS fraction bits; each output word carries
// angle_x (asin, within +-90 degrees), angle_y and angle_z (atan2, within
// +-180 degrees), all in 1/64 degree, with the gimbal clamp flag in tuser.
// The pipeline takes one word per cycle unless stalled and has 5 product/sum
// stages, 31 stages of the digit-by-digit square root, 14 operand
// normalization stages, a quadrant pre-rotation stage, CORDIC_STAGES
// vectoring stages, a rounding stage and the output register.
// Stalls hold the pipeline with bubbles squeezed out, nothing lost or
// repeated.
module quaternion_to_euler_angles
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES  = DEF_CORDIC_STAGES,
    parameter int QUAT_FRAC_BITS = DEF_QUAT_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // quat_x, quat_y, quat_z, quat_w
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // angle_x, angle_y, angle_z, zero fill
    output logic        o_m_axis_tuser   // gimbal_clamped
);

    logic              fr_valid, fr_ready;
    logic [RAD_W-1:0]  fr_rad;
    t_side             fr_side;
    logic              sq_valid, sq_ready;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;
    logic              ax_valid, ay_valid, az_valid;
    logic              ax_ready, ay_ready, az_ready;
    logic signed [ANG_W-1:0] ax_angle, ay_angle, az_angle;
    t_xflag            ax_flag, ay_flag, az_flag;
    logic signed [WIDE_W-1:0] x_num, x_den;
    logic              out_adv;

    logic                      r_ov;
    logic signed [ANGX_W-1:0]  r_angx;
    logic signed [ANGYZ_W-1:0] r_angy, r_angz;
    logic                      r_clamp;

    function automatic logic signed [ANG_W-1:0] sat(input logic signed [ANG_W-1:0] v,
                                                    input int lim);
        logic signed [ANG_W-1:0] l;
        l = ANG_W'(lim);
        if (v > l) begin
            return l;
        end else if (v < -l) begin
            return -l;
        end
        return v;
    endfunction

    qte_front #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_qx    (i_s_axis_tdata[15:0]),
        .i_qy    (i_s_axis_tdata[31:16]),
        .i_qz    (i_s_axis_tdata[47:32]),
        .i_qw    (i_s_axis_tdata[63:48]),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_rad   (fr_rad),
        .o_side  (fr_side)
    );

    qte_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_rad   (fr_rad),
        .i_side  (fr_side),
        .o_valid (sq_valid),
        .i_ready (sq_ready),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign x_num = sq_side.sneg ? -$signed(WIDE_W'(sq_side.s30)) : $signed(WIDE_W'(sq_side.s30));
    assign x_den = $signed(WIDE_W'(sq_root));

    // the three units share valid and ready, so they stay in lockstep
    assign sq_ready = ax_ready;
    assign out_adv  = !r_ov || i_m_axis_tready;

    qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (sq_valid), .o_ready (ax_ready),
        .i_num (x_num), .i_den (x_den),
        .i_flag ('{clamp: sq_side.clamp, sneg: sq_side.sneg}),
        .o_valid (ax_valid), .i_ready (out_adv),
        .o_angle (ax_angle), .o_flag (ax_flag)
    );

    qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (sq_valid), .o_ready (ay_ready),
        .i_num (sq_side.ny), .i_den (sq_side.dy),
        .i_flag ('{clamp: 1'b0, sneg: 1'b0}),
        .o_valid (ay_valid), .i_ready (out_adv),
        .o_angle (ay_angle), .o_flag (ay_flag)
    );

    qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (sq_valid), .o_ready (az_ready),
        .i_num (sq_side.nz), .i_den (sq_side.dz),
        .i_flag ('{clamp: 1'b0, sneg: 1'b0}),
        .o_valid (az_valid), .i_ready (out_adv),
        .o_angle (az_angle), .o_flag (az_flag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_adv) begin
            r_ov <= ax_valid && ay_valid && az_valid && ay_ready && az_ready
                    && (ay_flag == az_flag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_clamp <= ax_flag.clamp;
            if (ax_flag.clamp) begin
                r_angx <= ax_flag.sneg ? -ANGX_W'(ANGX_LIM) : ANGX_W'(ANGX_LIM);
            end else begin
                r_angx <= ANGX_W'(sat(ax_angle, ANGX_LIM));
            end
            r_angy <= ANGYZ_W'(sat(ay_angle, ANGYZ_LIM));
            r_angz <= ANGYZ_W'(sat(az_angle, ANGYZ_LIM));
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {4'b0, r_angz, r_angy, r_angx};
    assign o_m_axis_tuser  = r_clamp;

endmodule

// ===== rtl/core/qte_checker.sv =====
module qte_checker
    import qte_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [63:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    logic signed [ANGX_W-1:0]  w_ax;
    logic signed [ANGYZ_W-1:0] w_ay, w_az;

    assign w_ax = o_m_axis_tdata[13:0];
    assign w_ay = o_m_axis_tdata[28:14];
    assign w_az = o_m_axis_tdata[43:29];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output word changed under stall");

    a_xrange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_ax <= 14'sd5760) && (w_ax >= -14'sd5760))
        else $error("angle_x out of range");

    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> (w_ax == 14'sd5760) || (w_ax == -14'sd5760))
        else $error("clamped word without full-scale angle_x");

    a_yzrange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_ay <= 15'sd11520) && (w_ay >= -15'sd11520)
                         && (w_az <= 15'sd11520) && (w_az >= -15'sd11520)
                         && (o_m_axis_tdata[47:44] == 4'b0))
        else $error("angle_y or angle_z out of range");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);

// ===== test/quaternion_to_euler_angles_checker.sv =====
module quaternion_to_euler_angles_checker
    import qte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [47:0] i_out_data,
    input  logic        i_out_user,
    output int          o_errors,
    output int          o_pending,
    output int          o_words_in,
    output int          o_words_out,
    output int          o_clamps
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = DEF_CORDIC_STAGES;
    localparam int FRAC   = DEF_QUAT_FRAC_BITS;

    typedef struct packed {
        logic               clamp;
        logic signed [14:0] az;
        logic signed [14:0] ay;
        logic signed [13:0] ax;
    } t_angles;

    t_angles angle_q[$];

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return ~((~v) >>> s);
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint num, longint den);
        logic nneg, dneg;
        longint unsigned an, ad, mx;
        longint x, y, acc, t, xs, ys;
        nneg = num < 0;
        dneg = den < 0;
        an = nneg ? -num : num;
        ad = dneg ? -den : den;
        mx = an > ad ? an : ad;
        acc = 0;
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 30)) begin
            an >>= 1; ad >>= 1; mx >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            an <<= 1; ad <<= 1; mx <<= 1;
        end
        y = nneg ? -longint'(an) : longint'(an);
        x = dneg ? -longint'(ad) : longint'(ad);
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t;
                acc = 2 * longint'(ATAN_TAB[0]);
            end else begin
                t = x; x = -y; y = t;
                acc = -2 * longint'(ATAN_TAB[0]);
            end
        end
        for (int i = 0; i < STAGES && i < ATAN_TAB_LEN; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; acc += longint'(ATAN_TAB[i]);
            end else begin
                x -= ys; y += xs; acc -= longint'(ATAN_TAB[i]);
            end
        end
        return floor_shift(acc + (64'sd1 << (ANG_FRAC - 1)), ANG_FRAC);
    endfunction

    function automatic longint clip(longint v, longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic t_angles euler_of(logic [63:0] d);
        longint qx, qy, qz, qw, one, s, ny, dy, nz, dz, ax;
        longint unsigned smag, s30, c30;
        t_angles r;
        qx = longint'($signed(d[15:0]));
        qy = longint'($signed(d[31:16]));
        qz = longint'($signed(d[47:32]));
        qw = longint'($signed(d[63:48]));
        one = 64'sd1 << (2 * FRAC);
        s  = 2 * (qw * qx - qy * qz);
        ny = 2 * (qw * qy + qz * qx);
        dy = one - 2 * (qx * qx + qy * qy);
        nz = 2 * (qw * qz + qx * qy);
        dz = one - 2 * (qz * qz + qx * qx);
        smag = s < 0 ? -s : s;
        r.clamp = 1'b0;
        if (smag >= one) begin
            ax = s < 0 ? -ANGX_LIM : ANGX_LIM;
            r.clamp = 1'b1;
        end else begin
            if (2 * FRAC >= 30) s30 = smag >> (2 * FRAC - 30);
            else s30 = smag << (30 - 2 * FRAC);
            c30 = root_floor((64'd1 << 60) - s30 * s30);
            ax = clip(vector_angle(s < 0 ? -longint'(s30) : longint'(s30),
                                   longint'(c30)), ANGX_LIM);
        end
        r.ax = ax[13:0];
        r.ay = 15'(clip(vector_angle(ny, dy), ANGYZ_LIM));
        r.az = 15'(clip(vector_angle(nz, dz), ANGYZ_LIM));
        return r;
    endfunction

    assign o_pending = angle_q.size();

    always @(posedge i_clk) begin
        t_angles want, got;
        if (!i_rst_n) begin
            o_errors    <= 0;
            o_words_in  <= 0;
            o_words_out <= 0;
            o_clamps    <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                angle_q.push_back(euler_of(i_in_data));
                o_words_in <= o_words_in + 1;
            end
            if (i_out_valid && i_out_ready) begin
                o_words_out <= o_words_out + 1;
                got.ax    = i_out_data[13:0];
                got.ay    = i_out_data[28:14];
                got.az    = i_out_data[43:29];
                got.clamp = i_out_user;
                if (got.clamp) o_clamps <= o_clamps + 1;
                if (angle_q.size() == 0) begin
                    $display("%0t: unexpected word ax=%0d ay=%0d az=%0d clamp=%0b",
                             $time, got.ax, got.ay, got.az, got.clamp);
                    o_errors <= o_errors + 1;
                end else begin
                    want = angle_q.pop_front();
                    if (want.ax !== got.ax || want.ay !== got.ay ||
                        want.az !== got.az || want.clamp !== got.clamp) begin
                        $display("%0t: expected ax=%0d ay=%0d az=%0d clamp=%0b",
                                 $time, want.ax, want.ay, want.az, want.clamp);
                        $display("%0t: actual   ax=%0d ay=%0d az=%0d clamp=%0b",
                                 $time, got.ax, got.ay, got.az, got.clamp);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/quaternion_to_euler_angles_tb.sv =====
module quaternion_to_euler_angles_tb;
    import qte_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY  = DEF_CORDIC_STAGES + 53;
    localparam int N_RANDOM = 1380;
    localparam int WD_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] in_data;   // quat_x, quat_y, quat_z, quat_w
    logic        out_valid;
    logic        out_ready;
    logic [47:0] out_data;  // angle_x, angle_y, angle_z, zero fill
    logic        out_user;  // gimbal_clamped
    int          errors, pending, words_in, words_out, clamps;
    logic        hold_long;
    int          idle_cycles;

    quaternion_to_euler_angles dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_user)
    );

    quaternion_to_euler_angles_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_out_user  (out_user),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_words_in  (words_in),
        .o_words_out (words_out),
        .o_clamps    (clamps)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 32768) - 16384);
            1: return 16'($urandom_range(0, 2048) - 1024);
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 16) - 8);
        endcase
    endfunction

    // roughly unit quaternion: three random components, fourth from the remainder
    function automatic logic [63:0] unit_quat();
        longint c[4];
        longint rem;
        int k;
        rem = 64'sd1 << 28;
        k = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
            if (i != k) begin
                c[i] = longint'($urandom_range(0, 2 * 9400)) - 9400;
                rem -= c[i] * c[i];
            end
        end
        c[k] = 0;
        while ((c[k] + 1) * (c[k] + 1) <= rem) c[k]++;
        if ($urandom_range(0, 1)) c[k] = -c[k];
        return {16'(c[3]), 16'(c[2]), 16'(c[1]), 16'(c[0])};
    endfunction

    task automatic send_word(logic [63:0] d, bit gaps);
        int n;
        n = gaps ? $urandom_range(0, 7) : 0;
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // receiver: random stalls per word, long hold-offs while requested
    initial begin
        int n;
        out_ready = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_long) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            n = $urandom_range(0, 7);
            if (n > 0) begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WD_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] d;
        int mode;
        idle_cycles = 0;
        hold_long   = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, axes, clamps, extremes, degenerate operands
        send_word({16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 0);
        send_word({16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 0);
        send_word({16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 0);
        send_word({16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 0);
        send_word({16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, 0);
        send_word({16'sd11585, 16'sd0, 16'sd0, -16'sd11585}, 0);
        send_word({16'sd11586, 16'sd0, 16'sd0, 16'sd11586}, 0);
        send_word({16'sd11585, 16'sd0, 16'sd11585, 16'sd0}, 0);
        send_word({16'sd11585, 16'sd11585, 16'sd0, 16'sd0}, 0);
        send_word('0, 0);
        send_word({16'h8000, 16'h8000, 16'h8000, 16'h8000}, 0);
        send_word({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 0);
        send_word({16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 0);
        send_word({16'hffff, 16'hffff, 16'hffff, 16'hffff}, 0);
        send_word({16'sd0, 16'sd0, 16'sd0, 16'sd1}, 0);
        send_word({-16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 0);
        send_word({16'sd0, 16'sd0, 16'sd0, -16'sd16384}, 0);
        send_word({16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192}, 0);
        send_word({16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192}, 0);
        send_word({16'sd0, 16'sd0, 16'sd11585, 16'sd11585}, 0);
        in_valid <= 1'b0;

        // sender pauses until everything is back
        while (pending != 0) @(posedge clk);

        // receiver holds off while the sender keeps pushing
        hold_long <= 1'b1;
        for (int i = 0; i < 150; i++) send_word(unit_quat(), 0);
        hold_long <= 1'b0;

        for (int i = 0; i < N_RANDOM; i++) begin
            mode = $urandom_range(0, 9);
            if (mode < 6) d = unit_quat();
            else d = {rand_comp(mode - 6), rand_comp(mode - 6),
                      rand_comp(mode - 6), rand_comp(mode - 6)};
            send_word(d, (i / 200) % 2 == 0);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("%0d quaternions in, %0d angle words out, %0d with gimbal clamp",
                 words_in, words_out, clamps);
        $display("directed corners, unit and raw random inputs, long output stall");
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
